[sv/vrpr_pkg.sv]
package vrpr_pkg;

    localparam int FRAME_COUNT_BITS = 24;
    localparam int FRAME_LEN_BITS = 24;
    localparam int IN_DATA_BITS = 96;
    localparam int OUT_DATA_BITS = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] DESC_X = 8'b1000_0000;
    localparam logic [7:0] DESC_S = 8'b0001_0000;
    localparam logic [7:0] EXT_I = 8'b1000_0000;
    localparam logic [7:0] EXT_L = 8'b0100_0000;
    localparam logic [7:0] EXT_T = 8'b0010_0000;
    localparam logic [7:0] EXT_K = 8'b0001_0000;
    localparam logic [7:0] PIC_M = 8'b1000_0000;

    localparam logic [FRAME_COUNT_BITS-1:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OLD   = 2'd1,
        ST_EMPTY = 2'd2,
        ST_TRUNC = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0] seq_number;
        logic        marker;
        logic        start_bit;
        logic        last_in_buffer;
        t_status     status;
        logic [15:0] payload_offset;
        logic [15:0] payload_size;
    } t_queue_item;

    typedef struct packed {
        logic                      frame_ready;
        logic [FRAME_LEN_BITS-1:0] frame_length;
        logic [15:0]               payload_size;
        logic [15:0]               payload_offset;
        logic                      hold_current;
        logic                      clear_held;
        logic                      append_current;
        logic                      append_held;
        t_status                   status;
    } t_result;

endpackage

[sv/vp8_rtp_partition_reassembly_top.sv]
// VP8 RTP depacketizer control: each input transaction summarizes one RTP
// packet, and each output transaction tells the byte mover where the VP8 data
// lies, whether the packet was dropped, and how to append or hold payloads,
// together with the saturating frame length and, on the last packet of a
// buffer, whether a frame exists. A front stage parses the payload descriptor,
// a two-entry queue decouples it from the back stage that tracks sequence
// continuity and byte counts, and a registered output stage holds the result.
// One packet is taken per clock cycle while the queue has room and the output
// is not stalled; results are registered after the queue, and the single
// back-stage update of sequence and count state sets that rate.
module vp8_rtp_partition_reassembly_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // seq_number, packet_length, header_length, padding_length,
    // payload_byte0 .. payload_byte4, zero fill
    input  logic [vrpr_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
    // marker
    input  logic                                s_axis_tuser,
    // last_in_buffer
    input  logic                                s_axis_tlast,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // status, append_held, append_current, clear_held, hold_current,
    // payload_offset, payload_size, frame_length, frame_ready, zero fill
    output logic [vrpr_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
    import vrpr_pkg::*;

    t_queue_item front_item;
    t_queue_item back_item;
    t_result     result;
    logic        front_valid;
    logic        front_ready;
    logic        back_valid;
    logic        back_ready;

    vrpr_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .o_item_valid  (front_valid),
        .i_item_ready  (front_ready),
        .o_item        (front_item)
    );

    vrpr_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (front_valid),
        .o_wr_ready (front_ready),
        .i_wr_item  (front_item),
        .o_rd_valid (back_valid),
        .i_rd_ready (back_ready),
        .o_rd_item  (back_item)
    );

    vrpr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (back_valid),
        .o_item_ready (back_ready),
        .i_item       (back_item),
        .o_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .o_res        (result)
    );

    assign m_axis_tdata = {1'b0, result};

endmodule

[sv/vrpr_front.sv]
module vrpr_front (
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [vrpr_pkg::IN_DATA_BITS-1:0]      s_axis_tdata,
    input  logic                                   s_axis_tuser,
    input  logic                                   s_axis_tlast,
    output logic                                   o_item_valid,
    input  logic                                   i_item_ready,
    output vrpr_pkg::t_queue_item                  o_item
);
    import vrpr_pkg::*;

    logic [15:0] seq_number;
    logic [15:0] packet_length;
    logic [10:0] header_length;
    logic [7:0]  padding_length;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    logic [16:0] overhead;
    logic [15:0] avail;
    logic [2:0]  desc_len;
    logic        empty;
    logic        trunc;

    assign seq_number     = s_axis_tdata[15:0];
    assign packet_length  = s_axis_tdata[31:16];
    assign header_length  = s_axis_tdata[42:32];
    assign padding_length = s_axis_tdata[50:43];
    assign byte0          = s_axis_tdata[58:51];
    assign byte1          = s_axis_tdata[66:59];
    assign byte2          = s_axis_tdata[74:67];

    // The descriptor checks grow with its length, so it is truncated exactly
    // when the bytes left after headers and padding fall short of its length.
    always_comb begin
        desc_len = 3'd1;
        if ((byte0 & DESC_X) != 8'd0) begin
            desc_len = desc_len + 3'd1;
            if ((byte1 & EXT_I) != 8'd0) begin
                desc_len = desc_len + 3'd1;
                if ((byte2 & PIC_M) != 8'd0) begin
                    desc_len = desc_len + 3'd1;
                end
            end
            if ((byte1 & EXT_L) != 8'd0) begin
                desc_len = desc_len + 3'd1;
            end
            if ((byte1 & (EXT_T | EXT_K)) != 8'd0) begin
                desc_len = desc_len + 3'd1;
            end
        end
    end

    assign overhead = {6'd0, header_length} + {9'd0, padding_length};
    assign empty    = {1'b0, packet_length} <= overhead;
    assign avail    = packet_length - overhead[15:0];
    assign trunc    = avail < {13'd0, desc_len};

    always_comb begin
        o_item.seq_number     = seq_number;
        o_item.marker         = s_axis_tuser;
        o_item.start_bit      = (byte0 & DESC_S) != 8'd0;
        o_item.last_in_buffer = s_axis_tlast;
        o_item.status         = ST_OK;
        o_item.payload_offset = {5'd0, header_length} + {13'd0, desc_len};
        o_item.payload_size   = avail - {13'd0, desc_len};
        if (empty || trunc) begin
            o_item.status         = empty ? ST_EMPTY : ST_TRUNC;
            o_item.payload_offset = '0;
            o_item.payload_size   = '0;
        end
    end

    assign o_item_valid  = s_axis_tvalid;
    assign s_axis_tready = i_item_ready;

endmodule

[sv/vrpr_queue.sv]
module vrpr_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_valid,
    output logic                  o_wr_ready,
    input  vrpr_pkg::t_queue_item i_wr_item,
    output logic                  o_rd_valid,
    input  logic                  i_rd_ready,
    output vrpr_pkg::t_queue_item o_rd_item
);
    import vrpr_pkg::*;

    t_queue_item               r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] r_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] r_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] r_count;
    logic [QUEUE_PTR_BITS-1:0] n_wr_ptr;
    logic [QUEUE_PTR_BITS-1:0] n_rd_ptr;
    logic [QUEUE_CNT_BITS-1:0] n_count;
    logic                      push;
    logic                      pop;

    assign o_wr_ready = r_count != QUEUE_CNT_BITS'(QUEUE_DEPTH);
    assign o_rd_valid = r_count != '0;
    assign o_rd_item  = r_mem[r_rd_ptr];
    assign push       = i_wr_valid && o_wr_ready;
    assign pop        = o_rd_valid && i_rd_ready;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (push && !pop) begin
            n_count = r_count + QUEUE_CNT_BITS'(1);
        end else if (pop && !push) begin
            n_count = r_count - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_wr_item;
        end
    end

endmodule

[sv/vrpr_back.sv]
module vrpr_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_item_valid,
    output logic                  o_item_ready,
    input  vrpr_pkg::t_queue_item i_item,
    output logic                  o_res_valid,
    input  logic                  i_res_ready,
    output vrpr_pkg::t_result     o_res
);
    import vrpr_pkg::*;

    localparam int SUM_BITS = FRAME_COUNT_BITS + 2;

    logic [15:0]                 r_expected_seq;
    logic                        r_started;
    logic                        r_continuous;
    logic [FRAME_COUNT_BITS-1:0] r_held_bytes;
    logic [FRAME_COUNT_BITS-1:0] r_frame_bytes;
    logic                        r_res_valid;
    t_result                     r_res;

    logic [15:0]                 n_expected_seq;
    logic                        n_started;
    logic                        n_continuous;
    logic [FRAME_COUNT_BITS-1:0] n_held_bytes;
    logic [FRAME_COUNT_BITS-1:0] n_frame_bytes;
    t_result                     n_res;

    logic                        take;
    logic [15:0]                 exp_eff;
    logic                        cont_eff;
    logic                        add_held;
    logic                        add_cur;
    logic [FRAME_COUNT_BITS-1:0] held_base;
    logic [SUM_BITS-1:0]         frame_sum;
    logic [SUM_BITS-1:0]         held_sum;
    logic [FRAME_COUNT_BITS-1:0] frame_new;

    assign o_item_ready = !r_res_valid || i_res_ready;
    assign take         = i_item_valid && o_item_ready;
    assign exp_eff      = r_started ? r_expected_seq : i_item.seq_number;

    always_comb begin
        n_expected_seq = r_expected_seq;
        n_started      = 1'b1;
        n_continuous   = r_continuous;
        n_held_bytes   = r_held_bytes;
        n_res          = '0;
        n_res.status   = i_item.status;
        cont_eff       = r_continuous;
        add_held       = 1'b0;
        add_cur        = 1'b0;
        held_base      = r_held_bytes;
        if (i_item.seq_number < exp_eff) begin
            n_res.status = ST_OLD;
        end else begin
            if (i_item.seq_number > exp_eff) begin
                cont_eff = 1'b0;
            end
            n_continuous   = cont_eff;
            n_expected_seq = i_item.seq_number + 16'd1;
            if (i_item.status == ST_OK) begin
                n_res.payload_offset = i_item.payload_offset;
                n_res.payload_size   = i_item.payload_size;
                if (i_item.start_bit || i_item.marker) begin
                    if (cont_eff) begin
                        add_held             = 1'b1;
                        add_cur              = i_item.marker;
                        n_res.append_held    = 1'b1;
                        n_res.append_current = i_item.marker;
                    end
                    n_res.clear_held = 1'b1;
                    held_base        = '0;
                    n_held_bytes     = '0;
                    n_continuous     = 1'b1;
                end
                if (!i_item.marker) begin
                    n_res.hold_current = 1'b1;
                end
            end
        end
        frame_sum = {2'b00, r_frame_bytes}
                  + (add_held ? {2'b00, r_held_bytes} : '0)
                  + (add_cur ? SUM_BITS'(i_item.payload_size) : '0);
        frame_new = (frame_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX
                                                     : frame_sum[FRAME_COUNT_BITS-1:0];
        held_sum  = {2'b00, held_base} + SUM_BITS'(i_item.payload_size);
        if (n_res.hold_current) begin
            n_held_bytes = (held_sum > {2'b00, COUNT_MAX}) ? COUNT_MAX
                                                           : held_sum[FRAME_COUNT_BITS-1:0];
        end
        n_frame_bytes      = frame_new;
        n_res.frame_length = FRAME_LEN_BITS'(frame_new);
        if (i_item.last_in_buffer) begin
            n_res.frame_ready = frame_new != '0;
            n_expected_seq    = '0;
            n_started         = 1'b0;
            n_continuous      = 1'b0;
            n_held_bytes      = '0;
            n_frame_bytes     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_seq <= '0;
            r_started      <= 1'b0;
            r_continuous   <= 1'b0;
            r_held_bytes   <= '0;
            r_frame_bytes  <= '0;
            r_res_valid    <= 1'b0;
        end else begin
            if (take) begin
                r_expected_seq <= n_expected_seq;
                r_started      <= n_started;
                r_continuous   <= n_continuous;
                r_held_bytes   <= n_held_bytes;
                r_frame_bytes  <= n_frame_bytes;
                r_res_valid    <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_res <= n_res;
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule
